[hdl/lmt_pkg.sv]
// Shared types, request and status codes for the VLAN MAC learning table.
package lmt_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;

  localparam int MAC_W  = 48;
  localparam int VLAN_W = 12;
  localparam int PORT_W = 8;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LEARN           = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP_VLAN     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP_UNTAGGED = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FLUSH           = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ITER_RESET      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ITER_NEXT       = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  // How a stored entry is compared against the search key
  typedef enum logic [1:0] {
    MATCH_MAC_VLAN,
    MATCH_MAC_UNTAGGED,
    MATCH_VLAN
  } match_mode_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [VLAN_W-1:0] vlan;
    logic [PORT_W-1:0] port;
    logic              untagged;
  } entry_t;

  // Search key handed to the comparator
  typedef struct packed {
    match_mode_t       mode;
    logic [MAC_W-1:0]  mac;
    logic [VLAN_W-1:0] vlan;
  } key_t;

endpackage

[hdl/lmt_ram.sv]
// Entry memory: one write port, one synchronous read port.
module lmt_ram #(
  parameter int DEPTH = lmt_pkg::DEF_TABLE_ENTRIES,
  parameter int AW    = $clog2(lmt_pkg::DEF_TABLE_ENTRIES)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  lmt_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output lmt_pkg::entry_t rdata
);

  lmt_pkg::entry_t mem [DEPTH];

  // Write the new entry, read one entry a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/lmt_match.sv]
// Entry comparator: checks one read-back entry against the search key.
module lmt_match (
  input  lmt_pkg::key_t   key,
  input  lmt_pkg::entry_t entry,
  output logic            hit
);

  logic mac_eq;
  logic vlan_eq;

  assign mac_eq  = (entry.mac == key.mac);
  assign vlan_eq = (entry.vlan == key.vlan);

  // Select the comparison for the request kind
  always_comb begin
    case (key.mode)
      lmt_pkg::MATCH_MAC_VLAN:     hit = mac_eq && vlan_eq;
      lmt_pkg::MATCH_MAC_UNTAGGED: hit = mac_eq && entry.untagged;
      lmt_pkg::MATCH_VLAN:         hit = vlan_eq;
      default:                     hit = 1'b0;
    endcase
  end

endmodule

[hdl/vlan_mac_learning_table.sv]
// Top level of the VLAN-aware MAC learning table with scan controller.
//
// Usage: present a request on req_type, mac_address, vlan_id, egress_port
// and tagged_req and raise start; the item is taken at a clock edge where
// start is high and busy is low. Exactly one result per item appears on
// status, found_port and evicted for one cycle, marked by done. The
// receiver cannot stall, so done is never held.
// Entries sit in a ring in one synchronous memory. Learn and both lookups
// scan from newest to oldest, and iterator next from the iterator's age
// to oldest, one entry per cycle through the memory read port; each stops
// at the first match. Flush, iterator reset and unknown codes give done in
// the cycle after accept. busy is low while done is shown, so a new item
// may be taken then. Reset clears the fill count, newest pointer and
// iterator; the fill count marks which entries are live, so no clearing
// pass runs and the block accepts items in the first cycle after reset.
module vlan_mac_learning_table #(
  parameter int TABLE_ENTRIES = lmt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lmt_pkg::REQ_W-1:0]    req_type,
  input  logic [lmt_pkg::MAC_W-1:0]    mac_address,
  input  logic [lmt_pkg::VLAN_W-1:0]   vlan_id,
  input  logic [lmt_pkg::PORT_W-1:0]   egress_port,
  input  logic                         tagged_req,
  output logic                         done,
  output logic [lmt_pkg::STAT_W-1:0]   status,
  output logic [lmt_pkg::PORT_W-1:0]   found_port,
  output logic                         evicted
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int DW = CW + 1;
  localparam logic [AW-1:0] LAST_SLOT  = AW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                      state;
  logic [lmt_pkg::REQ_W-1:0]   req_q;
  lmt_pkg::key_t               key_q;
  logic [lmt_pkg::PORT_W-1:0]  port_q;
  logic                        tagged_q;
  logic [AW-1:0]               newest;
  logic [CW-1:0]               count;
  logic [CW-1:0]               iter;
  logic [AW-1:0]               scan_slot;
  logic [CW-1:0]               scan_age;
  logic                        data_vld;
  logic [CW-1:0]               data_age;

  lmt_pkg::entry_t             rdata;
  lmt_pkg::entry_t             wdata;
  lmt_pkg::match_mode_t        mode_in;
  logic                        hit;
  logic                        accept;
  logic                        issue_vld;
  logic                        scan_hit;
  logic                        scan_miss;
  logic                        learn_commit;
  logic                        count_full;
  logic [AW-1:0]               newest_inc;
  logic [AW-1:0]               slot_dec;
  logic [CW-1:0]               count_learn;
  logic [DW-1:0]               iter_inc;
  logic [CW-1:0]               iter_learn;
  logic [DW-1:0]               newest_ext;
  logic [DW-1:0]               iter_ext;
  logic [DW-1:0]               iter_diff;
  logic [AW-1:0]               iter_slot;

  // Handshake and scan progress
  assign busy      = (state == S_SCAN);
  assign accept    = start && !busy;
  assign issue_vld = (scan_age < count);
  assign scan_hit  = data_vld && hit;
  assign scan_miss = !scan_hit && !issue_vld;
  assign learn_commit = (state == S_SCAN) && (req_q == lmt_pkg::REQ_LEARN) && scan_miss;

  // Ring pointer steps
  assign newest_inc = (newest == LAST_SLOT) ? '0 : newest + 1'b1;
  assign slot_dec   = (scan_slot == '0) ? LAST_SLOT : scan_slot - 1'b1;

  // Fill count and iterator after a learn: everything ages by one
  assign count_full  = (count == FULL_COUNT);
  assign count_learn = count_full ? count : count + 1'b1;
  assign iter_inc    = {1'b0, iter} + 1'b1;
  assign iter_learn  = (iter_inc > {1'b0, count_learn}) ? count_learn : iter_inc[CW-1:0];

  // Slot of the entry at the iterator's age
  assign newest_ext = DW'(newest);
  assign iter_ext   = {1'b0, iter};
  assign iter_diff  = (newest_ext >= iter_ext) ? newest_ext - iter_ext
                                               : newest_ext + DW'(TABLE_ENTRIES) - iter_ext;
  assign iter_slot  = iter_diff[AW-1:0];

  // Comparison kind for the incoming request
  always_comb begin
    case (req_type)
      lmt_pkg::REQ_LOOKUP_UNTAGGED: mode_in = lmt_pkg::MATCH_MAC_UNTAGGED;
      lmt_pkg::REQ_ITER_NEXT:       mode_in = lmt_pkg::MATCH_VLAN;
      default:                      mode_in = lmt_pkg::MATCH_MAC_VLAN;
    endcase
  end

  // New entry for a learn
  always_comb begin
    wdata.mac      = key_q.mac;
    wdata.vlan     = key_q.vlan;
    wdata.port     = port_q;
    wdata.untagged = !tagged_q;
  end

  lmt_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (learn_commit),
    .waddr (newest_inc),
    .wdata (wdata),
    .raddr (scan_slot),
    .rdata (rdata)
  );

  lmt_match u_match (
    .key   (key_q),
    .entry (rdata),
    .hit   (hit)
  );

  // Controller: state, table bookkeeping and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      newest   <= '0;
      count    <= '0;
      iter     <= '0;
      data_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_q      <= req_type;
            key_q.mode <= mode_in;
            key_q.mac  <= mac_address;
            key_q.vlan <= vlan_id;
            port_q     <= egress_port;
            tagged_q   <= tagged_req;
            data_vld   <= 1'b0;
            found_port <= '0;
            evicted    <= 1'b0;
            case (req_type)
              lmt_pkg::REQ_LEARN, lmt_pkg::REQ_LOOKUP_VLAN,
              lmt_pkg::REQ_LOOKUP_UNTAGGED: begin
                scan_slot <= newest;
                scan_age  <= '0;
                state     <= S_SCAN;
              end
              lmt_pkg::REQ_ITER_NEXT: begin
                scan_slot <= iter_slot;
                scan_age  <= iter;
                state     <= S_SCAN;
              end
              lmt_pkg::REQ_FLUSH: begin
                count  <= '0;
                newest <= '0;
                iter   <= '0;
                done   <= 1'b1;
                status <= lmt_pkg::ST_OK;
              end
              lmt_pkg::REQ_ITER_RESET: begin
                iter   <= '0;
                done   <= 1'b1;
                status <= lmt_pkg::ST_OK;
              end
              default: begin
                done   <= 1'b1;
                status <= lmt_pkg::ST_MISS;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Advance the read pointer towards older entries
          data_vld <= issue_vld;
          data_age <= scan_age;
          if (issue_vld) begin
            scan_slot <= slot_dec;
            scan_age  <= scan_age + 1'b1;
          end
          // Finish on first match or when nothing is left to read
          if (scan_hit || scan_miss) begin
            state      <= S_IDLE;
            done       <= 1'b1;
            found_port <= '0;
            evicted    <= 1'b0;
            case (req_q)
              lmt_pkg::REQ_LEARN: begin
                if (scan_hit) begin
                  status <= lmt_pkg::ST_DUP;
                end else begin
                  status  <= lmt_pkg::ST_OK;
                  newest  <= newest_inc;
                  count   <= count_learn;
                  iter    <= iter_learn;
                  evicted <= count_full;
                end
              end
              lmt_pkg::REQ_ITER_NEXT: begin
                if (scan_hit) begin
                  status     <= lmt_pkg::ST_OK;
                  found_port <= rdata.port;
                  iter       <= data_age + 1'b1;
                end else begin
                  status <= lmt_pkg::ST_MISS;
                  iter   <= count;
                end
              end
              default: begin
                if (scan_hit) begin
                  status     <= lmt_pkg::ST_OK;
                  found_port <= rdata.port;
                end else begin
                  status <= lmt_pkg::ST_MISS;
                end
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("fill count beyond table size");

  // Iterator never stands past the live entries
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= count)
    else $error("iterator beyond fill count");

  // A stored entry is always followed by a successful learn result
  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    learn_commit |=> done && (status == lmt_pkg::ST_OK))
    else $error("entry written without learn result");

  // Flush answers at once and empties the table
  a_flush: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == lmt_pkg::REQ_FLUSH) |=> done && (count == '0) && !busy)
    else $error("flush did not complete in one cycle");

  // A match is only ever taken from a live entry
  a_hit_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && scan_hit |-> data_age < count)
    else $error("match on an entry outside the fill count");

endmodule
